// File: hdl/mkd_pkg.sv
// Types and constants shared by the Morse key decoder.
// Holds the event and status codes and the level-order Morse tree ROM.
// No dependencies.
package mkd_pkg;

   // Tree geometry: a full binary tree of TREE_LEVELS levels in level order
   localparam int TREE_LEVELS = 6;
   localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
   localparam int POS_W       = TREE_LEVELS;

   localparam int TIMER_W  = 8;
   localparam int EVENT_W  = 3;
   localparam int STATUS_W = 2;
   localparam int CHAR_W   = 7;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 3'd0,
      EV_DOT    = 3'd1,
      EV_DASH   = 3'd2,
      EV_LETTER = 3'd3,
      EV_WORD   = 3'd4
   } event_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NOTHING = 2'd0,
      ST_CHAR    = 2'd1,
      ST_ERROR   = 2'd2
   } status_type;

   // Register indexes on the CSR port (word addresses)
   typedef enum logic [1:0] {
      REG_DOT_TICKS    = 2'd0,
      REG_LETTER_TICKS = 2'd1,
      REG_WORD_TICKS   = 2'd2
   } reg_index_type;

   localparam logic [TIMER_W-1:0] DOT_TICKS_RST    = 8'd25;
   localparam logic [TIMER_W-1:0] LETTER_TICKS_RST = 8'd50;
   localparam logic [TIMER_W-1:0] WORD_TICKS_RST   = 8'd100;

   localparam logic [CHAR_W-1:0] CHAR_BAD = 7'h23;  // '#'

   // Morse tree, level order: dot child of i is 2i+1, dash child is 2i+2.
   // First character sits in the top byte.
   localparam logic [NODE_COUNT*8-1:0] TREE_ROM =
      "#ETIANMSURWDKGOHVF#L#PJBXCYZQ##54#3###2#######16#######7###8#90";

   // Character at a tree node; positions outside the tree read as '#'
   function automatic logic [CHAR_W-1:0] tree_char(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] slot;
      logic [7:0]       byte_val;
      slot     = POS_W'(NODE_COUNT - 1) - pos;
      byte_val = TREE_ROM[{slot, 3'b000} +: 8];
      if (32'(pos) >= NODE_COUNT) begin
         return CHAR_BAD;
      end
      return byte_val[CHAR_W-1:0];
   endfunction

endpackage

// File: hdl/morse_key_decoder.sv
// Morse key decoder top level: timing machine, tree walk, CSRs and result register.
// Depends on mkd_pkg.
//
//   port group | direction | handshake          | payload
//   req_*      | in        | req_valid/stall    | key_pressed, key_released
//   rsp_*      | out       | rsp_valid/stall    | key_event, decode_status, char_code
//   APB        | in/out    | psel/penable/pready| dot, letter and word gap ticks
//
// Each request gives exactly one response, registered and valid in the cycle after it is accepted.
// A request can be taken every cycle while req_stall is low; the single result register sets that rate.
// req_stall is high only while the result register is full and rsp_stall is high.
// Synchronous active-high reset: phase waits for a word, timers and tree
// position clear, gap registers return to 25/50/100 ticks.
module morse_key_decoder (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_key_pressed,
   input  logic                          req_key_released,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mkd_pkg::EVENT_W-1:0]   rsp_key_event,
   output logic [mkd_pkg::STATUS_W-1:0]  rsp_decode_status,
   output logic [mkd_pkg::CHAR_W-1:0]    rsp_char_code,
   // CSR port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   typedef enum logic [2:0] {
      PH_DOT,
      PH_DASH,
      PH_WORD,
      PH_LETTER,
      PH_PULSE
   } phase_type;

   localparam int TW = mkd_pkg::TIMER_W;
   localparam int PW = mkd_pkg::POS_W;

   phase_type                      phase_ff, phase_in;
   logic [TW-1:0]                  dot_timer_ff, dot_timer_in;
   logic [TW-1:0]                  letter_timer_ff, letter_timer_in;
   logic [TW-1:0]                  word_timer_ff, word_timer_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [TW-1:0]                  dot_ticks_ff, letter_ticks_ff, word_ticks_ff;
   logic                           rsp_valid_ff;
   mkd_pkg::event_type             event_ff, event_in;
   mkd_pkg::status_type            status_ff, status_in;
   logic [mkd_pkg::CHAR_W-1:0]     char_ff, char_in;

   logic                           req_take;
   logic                           csr_wr;
   mkd_pkg::reg_index_type         csr_idx;
   logic [TW-1:0]                  dot_dec, letter_dec, word_dec;
   logic [PW:0]                    child;
   logic [mkd_pkg::CHAR_W-1:0]     node_char;

   // Handshake: result register drains or is empty
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_key_event     = event_ff;
   assign rsp_decode_status = status_ff;
   assign rsp_char_code     = char_ff;

   // CSR decode
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = mkd_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         mkd_pkg::REG_DOT_TICKS:    prdata = 32'(dot_ticks_ff);
         mkd_pkg::REG_LETTER_TICKS: prdata = 32'(letter_ticks_ff);
         mkd_pkg::REG_WORD_TICKS:   prdata = 32'(word_ticks_ff);
         default:                   prdata = 32'd0;
      endcase
   end

   assign dot_dec    = dot_timer_ff - TW'(1);
   assign letter_dec = letter_timer_ff - TW'(1);
   assign word_dec   = word_timer_ff - TW'(1);
   assign node_char  = mkd_pkg::tree_char(pos_ff);

   // Timing machine and tree walk for one tick
   always_comb begin
      phase_in        = phase_ff;
      dot_timer_in    = dot_timer_ff;
      letter_timer_in = letter_timer_ff;
      word_timer_in   = word_timer_ff;
      pos_in          = pos_ff;
      event_in        = mkd_pkg::EV_NONE;
      status_in       = mkd_pkg::ST_NOTHING;
      char_in         = '0;
      child           = '0;

      unique case (phase_ff)
         PH_WORD: begin
            if (req_key_pressed) begin
               phase_in     = PH_DOT;
               dot_timer_in = dot_ticks_ff;
            end
         end
         PH_DOT: begin
            dot_timer_in = dot_dec;
            if (dot_dec == '0) begin
               dot_timer_in = dot_ticks_ff;
               phase_in     = PH_DASH;
            end else if (req_key_released) begin
               phase_in        = PH_PULSE;
               letter_timer_in = letter_ticks_ff;
               word_timer_in   = word_ticks_ff;
               event_in        = mkd_pkg::EV_DOT;
            end
         end
         PH_DASH: begin
            if (req_key_released) begin
               phase_in        = PH_PULSE;
               letter_timer_in = letter_ticks_ff;
               word_timer_in   = word_ticks_ff;
               event_in        = mkd_pkg::EV_DASH;
            end
         end
         PH_PULSE: begin
            letter_timer_in = letter_dec;
            word_timer_in   = word_dec;
            if (letter_dec == '0) begin
               phase_in = PH_LETTER;
               event_in = mkd_pkg::EV_LETTER;
            end else if (word_dec == '0) begin
               phase_in = PH_WORD;
               event_in = mkd_pkg::EV_WORD;
            end else if (req_key_pressed) begin
               phase_in     = PH_DOT;
               dot_timer_in = dot_ticks_ff;
            end
         end
         PH_LETTER: begin
            word_timer_in = word_dec;
            if (word_dec == '0) begin
               phase_in = PH_WORD;
               event_in = mkd_pkg::EV_WORD;
            end else if (req_key_pressed) begin
               phase_in     = PH_DOT;
               dot_timer_in = dot_ticks_ff;
            end
         end
         default: phase_in = PH_WORD;
      endcase

      // Tree step on dot/dash; stepping past a leaf is an error
      if (event_in == mkd_pkg::EV_DOT || event_in == mkd_pkg::EV_DASH) begin
         child = {pos_ff, 1'b0} + ((event_in == mkd_pkg::EV_DOT) ? (PW+1)'(1) : (PW+1)'(2));
         if (32'(child) >= mkd_pkg::NODE_COUNT) begin
            pos_in    = '0;
            status_in = mkd_pkg::ST_ERROR;
            char_in   = mkd_pkg::CHAR_BAD;
         end else begin
            pos_in = child[PW-1:0];
         end
      end else if (event_in == mkd_pkg::EV_LETTER && pos_ff != '0) begin
         // End of letter: report the node, '#' nodes are errors
         pos_in = '0;
         if (node_char == mkd_pkg::CHAR_BAD) begin
            status_in = mkd_pkg::ST_ERROR;
            char_in   = mkd_pkg::CHAR_BAD;
         end else begin
            status_in = mkd_pkg::ST_CHAR;
            char_in   = node_char;
         end
      end
   end

   // State, CSRs and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WORD;
         dot_timer_ff    <= '0;
         letter_timer_ff <= '0;
         word_timer_ff   <= '0;
         pos_ff          <= '0;
         dot_ticks_ff    <= mkd_pkg::DOT_TICKS_RST;
         letter_ticks_ff <= mkd_pkg::LETTER_TICKS_RST;
         word_ticks_ff   <= mkd_pkg::WORD_TICKS_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_idx)
               mkd_pkg::REG_DOT_TICKS:    dot_ticks_ff    <= pwdata[TW-1:0];
               mkd_pkg::REG_LETTER_TICKS: letter_ticks_ff <= pwdata[TW-1:0];
               mkd_pkg::REG_WORD_TICKS:   word_ticks_ff   <= pwdata[TW-1:0];
               default: ;
            endcase
         end
         if (req_take) begin
            phase_ff        <= phase_in;
            dot_timer_ff    <= dot_timer_in;
            letter_timer_ff <= letter_timer_in;
            word_timer_ff   <= word_timer_in;
            pos_ff          <= pos_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         event_ff  <= event_in;
         status_ff <= status_in;
         char_ff   <= char_in;
      end
   end

   // Checks
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_char_only_on_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mkd_pkg::ST_CHAR |-> event_ff == mkd_pkg::EV_LETTER)
      else $error("character decoded without a letter gap");

   a_nothing_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mkd_pkg::ST_NOTHING |-> char_ff == '0)
      else $error("char code set with nothing decoded");

   a_error_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mkd_pkg::ST_ERROR |-> char_ff == mkd_pkg::CHAR_BAD)
      else $error("error without '#'");

   a_pos_in_tree: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < mkd_pkg::NODE_COUNT)
      else $error("tree position left the tree");

endmodule
